@@ rtl/core/slot_table_lowest_match_core_defines.svh @@
// Assertion macros shared by the slot table RTL.
// Each use names its own label, the two sides of the implication and a message.
`ifndef SLOT_TABLE_LOWEST_MATCH_CORE_DEFINES_SVH
`define SLOT_TABLE_LOWEST_MATCH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, ignored while rst_n is low.
`define STLM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, ignored while rst_n is low.
`define STLM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/stlm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package stlm_pkg;

    localparam int SLOTS_DEF      = 64;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field widths of the channel words
    localparam int SLOT_W  = 6;
    localparam int VALUE_W = 32;

    localparam logic KIND_CHANGE = 1'b0;
    localparam logic KIND_FIND   = 1'b1;

    // Control part of a word travelling down the cell chain
    typedef struct packed {
        logic              vld;
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
    } stlm_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/stlm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface stlm_item_if;
    import stlm_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [SLOT_W-1:0]   slot;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, output kind, output slot, output value, input ready);
    modport sink   (input valid, input kind, input slot, input value, output ready);
endinterface

interface stlm_result_if;
    import stlm_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [SLOT_W-1:0] found_slot;

    modport source (output valid, output found, output found_slot, input ready);
    modport sink   (input valid, input found, input found_slot, output ready);
endinterface

`default_nettype wire

@@ rtl/core/slot_table_lowest_match_core.sv @@
// A find word's result passes the SLOTS cell registers and then the output register.
// Throughput: one word per cycle; every word walks the chain of SLOTS cells, one cell
// a cycle; the whole chain holds while the output register's result is not taken.
// Change words give no result. Reset (rst_n low, asynchronous) clears every slot's
// valid mark, the chain control and the result valid flag; slot values stay undefined.
`timescale 1ns / 1ps
`default_nettype none

`include "slot_table_lowest_match_core_defines.svh"

module slot_table_lowest_match_core #(
    parameter int SLOTS      = stlm_pkg::SLOTS_DEF,
    parameter int VALUE_BITS = stlm_pkg::VALUE_BITS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    stlm_item_if.sink      item,
    stlm_result_if.source  result
);
    import stlm_pkg::*;

    stlm_ctl_t             ctl_chain   [SLOTS+1];
    logic [VALUE_BITS-1:0] value_chain [SLOTS+1];

    logic              adv;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              found_reg;
    logic [SLOT_W-1:0] found_slot_reg;
    stlm_ctl_t         last;

    // Advance the chain whenever the output register is free or being drained
    assign adv        = !out_valid_reg || result.ready;
    assign item.ready = adv;

    always_comb
    begin
        ctl_chain[0]          = '0;
        ctl_chain[0].vld      = item.valid;
        ctl_chain[0].kind     = item.kind;
        ctl_chain[0].slot     = item.slot;
    end

    assign value_chain[0] = VALUE_BITS'(item.value);

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        stlm_cell #(
            .IDX        (i),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .ctl_in    (ctl_chain[i]),
            .value_in  (value_chain[i]),
            .ctl_out   (ctl_chain[i+1]),
            .value_out (value_chain[i+1])
        );
    end

    assign last = ctl_chain[SLOTS];

    // Drop change words at the end of the chain
    assign out_valid_next = adv ? (last.vld && (last.kind == KIND_FIND)) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            found_reg      <= last.hit;
            found_slot_reg <= last.hit_slot;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.found      = found_reg;
    assign result.found_slot = found_slot_reg;

    `STLM_ASSERT_IMP(a_miss_slot_zero, out_valid_reg && !found_reg,
        found_slot_reg == '0, "miss result carries a nonzero slot")
    `STLM_ASSERT_IMP(a_hit_in_range, out_valid_reg && found_reg,
        32'(found_slot_reg) < SLOTS, "hit slot beyond table depth")
    `STLM_ASSERT_NXT(a_find_delivered, adv && last.vld && (last.kind == KIND_FIND),
        out_valid_reg, "find word left the chain without a result")
    `STLM_ASSERT_NXT(a_change_silent, adv && !(last.vld && (last.kind == KIND_FIND)),
        !out_valid_reg, "result shown without a find word")

endmodule

`default_nettype wire

@@ rtl/core/stlm_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stlm_cell #(
    parameter int IDX        = 0,
    parameter int VALUE_BITS = stlm_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  adv,
    input  wire stlm_pkg::stlm_ctl_t   ctl_in,
    input  wire logic [VALUE_BITS-1:0] value_in,
    output stlm_pkg::stlm_ctl_t        ctl_out,
    output logic [VALUE_BITS-1:0]      value_out
);
    import stlm_pkg::*;

    // Cells past the reach of the slot field can never be written
    localparam bit ADDRESSABLE = (IDX < (1 << SLOT_W));

    logic [VALUE_BITS-1:0] slot_val_reg;
    logic [VALUE_BITS-1:0] slot_val_next;
    logic                  slot_vld_reg;
    logic                  slot_vld_next;
    stlm_ctl_t             ctl_reg;
    stlm_ctl_t             ctl_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  addr_hit;
    logic                  write_en;
    logic                  match;

    assign addr_hit = ADDRESSABLE && (ctl_in.slot == SLOT_W'(IDX));
    assign write_en = adv && ctl_in.vld && (ctl_in.kind == KIND_CHANGE) && addr_hit;
    assign match    = ctl_in.vld && (ctl_in.kind == KIND_FIND) && !ctl_in.hit
                      && slot_vld_reg && (slot_val_reg == value_in);

    always_comb
    begin
        slot_val_next = write_en ? value_in : slot_val_reg;
        slot_vld_next = slot_vld_reg | write_en;
        ctl_next      = ctl_in;
        // Lower cells claim the word first; pass on the earlier hit untouched
        if (match)
        begin
            ctl_next.hit      = 1'b1;
            ctl_next.hit_slot = SLOT_W'(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= 1'b0;
            ctl_reg      <= '0;
        end
        else if (adv)
        begin
            slot_vld_reg <= slot_vld_next;
            ctl_reg      <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_val_reg <= slot_val_next;
        if (adv)
        begin
            value_reg <= value_in;
        end
    end

    assign ctl_out   = ctl_reg;
    assign value_out = value_reg;

endmodule

`default_nettype wire
